// ===== hw/rtl/vrt_pkg.sv =====
// ---------------------------------------------------------------------------
// vrt_pkg
// Shared types, codes and constants of the 3-D voxel ray traversal block.
// ---------------------------------------------------------------------------
package vrt_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int STEP_BITS_DEF  = 10;

  localparam int DIST_W = 24;
  localparam int MSTEP_W = 10;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 24'hFFFFFF;
  localparam logic [MSTEP_W-1:0] STEP_LIM_RST = 10'd256;

  typedef enum logic [2:0] {
    ST_TEST       = 3'd0,
    ST_HIT        = 3'd1,
    ST_BEYOND     = 3'd2,
    ST_STEP_LIMIT = 3'd3,
    ST_ZERO_DIR   = 3'd4,
    ST_COORD_OVF  = 3'd5
  } vrt_status_t;

  typedef enum logic [2:0] {
    FACE_NORTH = 3'd0,
    FACE_SOUTH = 3'd1,
    FACE_EAST  = 3'd2,
    FACE_WEST  = 3'd3,
    FACE_UP    = 3'd4,
    FACE_DOWN  = 3'd5
  } vrt_face_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_START,
    OP_MUL,
    OP_AXIS_WR,
    OP_START_END,
    OP_EVAL,
    OP_VERD_END
  } vrt_op_t;

  typedef struct packed {
    vrt_op_t    op;
    logic [1:0] axis;
  } vrt_cmd_t;

  typedef struct packed {
    logic func;
    logic zero_dir;
    logic origin_ovf;
    logic ray_active;
    logic div_done;
    logic out_free;
  } vrt_sts_t;

  typedef struct packed {
    logic               func;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [23:0]        range_limit;
    logic               voxel_solid;
  } vrt_in_t;

  typedef struct packed {
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
    logic [2:0]         face;
    logic [2:0]         status;
    logic [23:0]        hit_distance;
    logic [9:0]         tested_cnt;
  } vrt_out_t;

endpackage

// ===== hw/rtl/vrt_div.sv =====
// ---------------------------------------------------------------------------
// vrt_div
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// ---------------------------------------------------------------------------
module vrt_div #(
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [15:0]   dvs_r, dvs_nxt;
  logic [16:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, q_r[QW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 16'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== hw/rtl/vrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// vrt_ctrl
// Sequencer: accepts requests, runs ray setup per axis, issues results.
// ---------------------------------------------------------------------------
module vrt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrt_pkg::vrt_sts_t sts,
  output vrt_pkg::vrt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DSTART,
    S_DIV,
    S_MUL,
    S_WR,
    S_START_OUT,
    S_VERD_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd.op    = vrt_pkg::OP_NONE;
    cmd.axis  = axis_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = vrt_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!sts.func) begin
          if (sts.zero_dir || sts.origin_ovf) begin
            state_nxt = S_START_OUT;
          end else begin
            axis_nxt  = vrt_pkg::AXIS_X;
            state_nxt = S_DSTART;
          end
        end else if (!sts.ray_active) begin
          state_nxt = S_IDLE;  // drop verdict with no ray
        end else begin
          cmd.op    = vrt_pkg::OP_EVAL;
          state_nxt = S_VERD_OUT;
        end
      end
      S_DSTART: begin
        cmd.op    = vrt_pkg::OP_DIV_START;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = vrt_pkg::OP_MUL;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.op = vrt_pkg::OP_AXIS_WR;
        if (axis_r == vrt_pkg::AXIS_Z) begin
          state_nxt = S_START_OUT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_DSTART;
        end
      end
      S_START_OUT: begin
        if (sts.out_free) begin
          cmd.op    = vrt_pkg::OP_START_END;
          state_nxt = S_IDLE;
        end
      end
      S_VERD_OUT: begin
        if (sts.out_free) begin
          cmd.op    = vrt_pkg::OP_VERD_END;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= vrt_pkg::AXIS_X;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== hw/rtl/vrt_datapath.sv =====
// ---------------------------------------------------------------------------
// vrt_datapath
// Ray state, setup arithmetic, stepping decision and the result register.
// ---------------------------------------------------------------------------
module vrt_datapath #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
  parameter int STEP_BITS  = vrt_pkg::STEP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vrt_pkg::vrt_cmd_t cmd,
  output vrt_pkg::vrt_sts_t sts,
  input  vrt_pkg::vrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrt_pkg::vrt_out_t out_data,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_wdata
);

  localparam int QW = 16 + FRAC_BITS;
  localparam int PW = FRAC_BITS + 25;
  localparam int LW = (STEP_BITS > 10) ? STEP_BITS : 10;
  localparam logic signed [24:0] CMAX = (25'sd1 <<< (COORD_BITS - 1)) - 25'sd1;
  localparam logic signed [24:0] CMIN = -(25'sd1 <<< (COORD_BITS - 1));
  localparam logic [STEP_BITS-1:0] STEP_MAX = {STEP_BITS{1'b1}};

  function automatic logic [15:0] vox16(input logic signed [COORD_BITS-1:0] v);
    logic signed [COORD_BITS+15:0] w;
    w = (COORD_BITS+16)'(v);
    return w[15:0];
  endfunction

  vrt_pkg::vrt_in_t       in_r;
  logic [9:0]             step_lim_r;
  logic                   active_r;
  logic signed [COORD_BITS-1:0] cur_r [3];
  logic [23:0]            nb_r [3];
  logic [23:0]            delta_r [3];
  logic [2:0]             sign_r;
  logic [2:0]             face_r;
  logic [STEP_BITS-1:0]   cnt_r;
  logic [23:0]            travel_r;
  logic [PW-1:0]          prod_r;
  logic [23:0]            dsat_r;
  logic [1:0]             ax_r;
  logic [23:0]            selb_r;
  logic                   out_valid_r;
  vrt_pkg::vrt_out_t      out_r;

  logic signed [23:0]     org [3];
  logic signed [15:0]     dir [3];
  logic signed [24:0]     vox25 [3];
  logic [2:0]             vox_ovf;
  logic [2:0]             dir_pos;
  logic [2:0]             dir_zero;

  always_comb begin
    org[0] = in_r.origin_x;
    org[1] = in_r.origin_y;
    org[2] = in_r.origin_z;
    dir[0] = in_r.dir_x;
    dir[1] = in_r.dir_y;
    dir[2] = in_r.dir_z;
    for (int i = 0; i < 3; i++) begin
      vox25[i]    = 25'(org[i] >>> FRAC_BITS);
      vox_ovf[i]  = (vox25[i] > CMAX) || (vox25[i] < CMIN);
      dir_zero[i] = (dir[i] == 16'sd0);
      dir_pos[i]  = !dir[i][15] && !dir_zero[i];
    end
  end

  // per-axis setup operands
  logic signed [15:0]   dsel;
  logic [15:0]          mag;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS:0]   part;
  logic                 div_busy;
  logic [QW-1:0]        quot;
  logic [QW+23:0]       quot_ext;
  logic [23:0]          dsat;
  logic [24:0]          shifted;

  always_comb begin
    dsel     = dir[cmd.axis];
    mag      = dsel[15] ? 16'(-dsel) : 16'(dsel);
    frac     = org[cmd.axis][FRAC_BITS-1:0];
    part     = dir_pos[cmd.axis] ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac})
                                 : {1'b0, frac};
    quot_ext = (QW+24)'(quot);
    dsat     = (quot_ext > (QW+24)'(vrt_pkg::DIST_MAX)) ? vrt_pkg::DIST_MAX
                                                       : quot_ext[23:0];
    shifted  = prod_r[PW-1:FRAC_BITS];
  end

  vrt_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == vrt_pkg::OP_DIV_START),
    .dividend (QW'(1) << (QW - 1)),
    .divisor  (mag),
    .busy     (div_busy),
    .quotient (quot)
  );

  // stepping decision
  logic [1:0]                 ax_sel;
  logic signed [COORD_BITS:0] nv;
  logic                       nv_ovf;
  logic [24:0]                nb_sum;
  logic [LW-1:0]              lim_ms, lim_max, limit;
  logic                       at_limit;
  logic [STEP_BITS+9:0]       cnt_ext;

  always_comb begin
    if (nb_r[0] < nb_r[1] && nb_r[0] < nb_r[2]) begin
      ax_sel = vrt_pkg::AXIS_X;
    end else if (nb_r[1] < nb_r[2]) begin
      ax_sel = vrt_pkg::AXIS_Y;
    end else begin
      ax_sel = vrt_pkg::AXIS_Z;
    end
    if (sign_r[ax_r]) begin
      nv = (COORD_BITS+1)'(cur_r[ax_r]) + (COORD_BITS+1)'(1);
    end else begin
      nv = (COORD_BITS+1)'(cur_r[ax_r]) - (COORD_BITS+1)'(1);
    end
    nv_ovf   = nv[COORD_BITS] != nv[COORD_BITS-1];
    nb_sum   = {1'b0, nb_r[ax_r]} + {1'b0, delta_r[ax_r]};
    lim_ms   = LW'(step_lim_r);
    lim_max  = LW'(STEP_MAX);
    limit    = (lim_ms < lim_max) ? lim_ms : lim_max;
    at_limit = LW'(cnt_r) >= limit;
    cnt_ext  = (STEP_BITS+10)'(cnt_r);
  end

  // result assembly
  vrt_pkg::vrt_out_t out_nxt;
  logic              emit;

  always_comb begin
    emit    = 1'b0;
    out_nxt = '0;
    out_nxt.voxel_x    = vox16(cur_r[0]);
    out_nxt.voxel_y    = vox16(cur_r[1]);
    out_nxt.voxel_z    = vox16(cur_r[2]);
    out_nxt.tested_cnt = cnt_ext[9:0];
    if (cmd.op == vrt_pkg::OP_START_END) begin
      emit = 1'b1;
      out_nxt.voxel_x    = vox25[0][15:0];
      out_nxt.voxel_y    = vox25[1][15:0];
      out_nxt.voxel_z    = vox25[2][15:0];
      out_nxt.tested_cnt = '0;
      if (&dir_zero) begin
        out_nxt.status = vrt_pkg::ST_ZERO_DIR;
      end else if (|vox_ovf) begin
        out_nxt.status = vrt_pkg::ST_COORD_OVF;
      end else begin
        out_nxt.status = vrt_pkg::ST_TEST;
      end
    end else if (cmd.op == vrt_pkg::OP_VERD_END) begin
      emit = 1'b1;
      if (in_r.voxel_solid) begin
        out_nxt.status       = vrt_pkg::ST_HIT;
        out_nxt.face         = face_r;
        out_nxt.hit_distance = selb_r;
      end else if (selb_r > travel_r) begin
        out_nxt.status = vrt_pkg::ST_BEYOND;
      end else if (at_limit) begin
        out_nxt.status = vrt_pkg::ST_STEP_LIMIT;
      end else if (nv_ovf) begin
        out_nxt.status = vrt_pkg::ST_COORD_OVF;
      end else begin
        out_nxt.status = vrt_pkg::ST_TEST;
        case (ax_r)
          vrt_pkg::AXIS_X: begin
            out_nxt.voxel_x = vox16(nv[COORD_BITS-1:0]);
            out_nxt.face    = sign_r[0] ? vrt_pkg::FACE_WEST : vrt_pkg::FACE_EAST;
          end
          vrt_pkg::AXIS_Y: begin
            out_nxt.voxel_y = vox16(nv[COORD_BITS-1:0]);
            out_nxt.face    = sign_r[1] ? vrt_pkg::FACE_DOWN : vrt_pkg::FACE_UP;
          end
          default: begin
            out_nxt.voxel_z = vox16(nv[COORD_BITS-1:0]);
            out_nxt.face    = sign_r[2] ? vrt_pkg::FACE_NORTH : vrt_pkg::FACE_SOUTH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_lim_r  <= vrt_pkg::STEP_LIM_RST;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      face_r      <= vrt_pkg::FACE_NORTH;
      cnt_r       <= '0;
      travel_r    <= '0;
      sign_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        cur_r[i]   <= '0;
        nb_r[i]    <= '0;
        delta_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        step_lim_r <= cfg_wdata;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        vrt_pkg::OP_LOAD: begin
          if (!in_data.func) begin
            active_r <= 1'b0;
            cnt_r    <= '0;
            face_r   <= vrt_pkg::FACE_NORTH;
            travel_r <= in_data.range_limit;
          end
        end
        vrt_pkg::OP_AXIS_WR: begin
          if (dir_zero[cmd.axis]) begin
            delta_r[cmd.axis] <= vrt_pkg::DIST_MAX;
            nb_r[cmd.axis]    <= vrt_pkg::DIST_MAX;
          end else begin
            delta_r[cmd.axis] <= dsat_r;
            nb_r[cmd.axis]    <= shifted[24] ? vrt_pkg::DIST_MAX : shifted[23:0];
          end
        end
        vrt_pkg::OP_START_END: begin
          if (!(&dir_zero) && !(|vox_ovf)) begin
            active_r <= 1'b1;
            sign_r   <= dir_pos;
            for (int i = 0; i < 3; i++) begin
              cur_r[i] <= vox25[i][COORD_BITS-1:0];
            end
          end
        end
        vrt_pkg::OP_EVAL: begin
          if (cnt_r != STEP_MAX) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        vrt_pkg::OP_VERD_END: begin
          if (in_r.voxel_solid || selb_r > travel_r || at_limit || nv_ovf) begin
            active_r <= 1'b0;
          end else begin
            cur_r[ax_r] <= nv[COORD_BITS-1:0];
            nb_r[ax_r]  <= nb_sum[24] ? vrt_pkg::DIST_MAX : nb_sum[23:0];
            face_r      <= out_nxt.face;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.op == vrt_pkg::OP_LOAD) begin
      in_r <= in_data;
    end
    if (cmd.op == vrt_pkg::OP_MUL) begin
      prod_r <= PW'(part) * PW'(dsat);
      dsat_r <= dsat;
    end
    if (cmd.op == vrt_pkg::OP_EVAL) begin
      ax_r   <= ax_sel;
      selb_r <= nb_r[ax_sel];
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    sts.func       = in_r.func;
    sts.zero_dir   = &dir_zero;
    sts.origin_ovf = |vox_ovf;
    sts.ray_active = active_r;
    sts.div_done   = !div_busy;
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/voxel_ray_traversal.sv =====
// ---------------------------------------------------------------------------
// voxel_ray_traversal
// 3-D DDA voxel stepper: ray setup with reciprocal deltas, then one step
// per verdict request.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall    vrt_pkg::vrt_in_t
//   out_     output     out_valid/out_stall  vrt_pkg::vrt_out_t
//   cfg_     input      cfg_we               step limit (10 bits)
//
// A start request is answered after three passes of the shared
// one-bit-per-cycle reciprocal divider, one per axis; the next request
// is taken only after the answer. A verdict request is evaluated and
// answered before the next is taken; a verdict with no active ray is
// dropped; a start with a zero direction or an out-of-range origin skips
// the divider and is answered directly.
// Reset (rst_n low, synchronous) clears the ray and sets the step limit to 256.
// A new request is taken while the last result still waits in the output
// register; out_stall holds that register and delays the next result and the requests after it.
// ---------------------------------------------------------------------------
module voxel_ray_traversal #(
  parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
  parameter int STEP_BITS  = vrt_pkg::STEP_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrt_pkg::vrt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrt_pkg::vrt_out_t out_data,
  input  logic              cfg_we,
  input  logic [9:0]        cfg_wdata
);

  vrt_pkg::vrt_cmd_t cmd;
  vrt_pkg::vrt_sts_t sts;

  vrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrt_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule

// ===== sim/tb_voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_voxel_ray_traversal
// Self-checking bench for the voxel ray stepper. Start and verdict requests
// go in with random gaps, except in the last phase. A scoreboard predicts every result and compares
// the results in order, field by field. The step limit is changed between
// phases while the block is idle.
// ---------------------------------------------------------------------------

class vrt_scoreboard;
  logic [9:0]        step_cap;
  bit                active;
  logic signed [16:0] vox [3];
  logic [23:0]       bnd [3];
  logic [23:0]       dlt [3];
  bit                pos [3];
  logic [2:0]        face;
  logic [9:0]        count;
  logic [23:0]       travel;
  vrt_pkg::vrt_out_t pending [$];
  int                errors;
  int                hits;
  int                ends;

  function new();
    step_cap = vrt_pkg::STEP_LIM_RST;
    active = 0;
    errors = 0;
    hits = 0;
    ends = 0;
  endfunction

  function logic [23:0] sat(longint v);
    return (v > 64'hFFFFFF) ? vrt_pkg::DIST_MAX : v[23:0];
  endfunction

  function void push(logic signed [16:0] x, logic signed [16:0] y,
                     logic signed [16:0] z, logic [2:0] f,
                     vrt_pkg::vrt_status_t s, logic [23:0] d, logic [9:0] n);
    vrt_pkg::vrt_out_t r;
    r.voxel_x = x[15:0];
    r.voxel_y = y[15:0];
    r.voxel_z = z[15:0];
    r.face = f;
    r.status = s;
    r.hit_distance = d;
    r.tested_cnt = n;
    pending.insert(pending.size(), r);
  endfunction

  function void note_request(vrt_pkg::vrt_in_t q);
    longint o, fr, v, mag, dv, part, nv;
    longint sd [3];
    longint ov [3];
    bit ovf;
    int ax;
    logic [23:0] m;
    logic [9:0] lim;
    if (!q.func) begin
      active = 0;
      count = '0;
      face = vrt_pkg::FACE_NORTH;
      travel = q.range_limit;
      ov[0] = q.origin_x; ov[1] = q.origin_y; ov[2] = q.origin_z;
      sd[0] = q.dir_x; sd[1] = q.dir_y; sd[2] = q.dir_z;
      ovf = 0;
      for (int i = 0; i < 3; i++) begin
        o = ov[i];
        fr = o & 255;
        v = (o - fr) / 256;
        if (v < -32768 || v > 32767) ovf = 1;
        vox[i] = 17'(v);
      end
      if (sd[0] == 0 && sd[1] == 0 && sd[2] == 0) begin
        push(vox[0], vox[1], vox[2], vrt_pkg::FACE_NORTH, vrt_pkg::ST_ZERO_DIR, '0, '0);
        ends++;
        return;
      end
      if (ovf) begin
        push(vox[0], vox[1], vox[2], vrt_pkg::FACE_NORTH, vrt_pkg::ST_COORD_OVF, '0, '0);
        ends++;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        fr = ov[i] & 255;
        mag = sd[i] < 0 ? -sd[i] : sd[i];
        pos[i] = sd[i] > 0;
        if (mag == 0) begin
          dlt[i] = vrt_pkg::DIST_MAX;
          bnd[i] = vrt_pkg::DIST_MAX;
        end else begin
          dv = sat((64'd1 << 23) / mag);
          part = pos[i] ? (256 - fr) : fr;
          dlt[i] = 24'(dv);
          bnd[i] = sat((part * dv) >> 8);
        end
      end
      active = 1;
      push(vox[0], vox[1], vox[2], face, vrt_pkg::ST_TEST, '0, count);
      return;
    end
    if (!active) return;
    if (count < 10'h3FF) count++;
    if (q.voxel_solid) begin
      m = bnd[0];
      if (bnd[1] < m) m = bnd[1];
      if (bnd[2] < m) m = bnd[2];
      active = 0;
      hits++;
      push(vox[0], vox[1], vox[2], face, vrt_pkg::ST_HIT, m, count);
      return;
    end
    if (bnd[0] < bnd[1] && bnd[0] < bnd[2]) ax = 0;
    else if (bnd[1] < bnd[2]) ax = 1;
    else ax = 2;
    if (bnd[ax] > travel) begin
      active = 0;
      ends++;
      push(vox[0], vox[1], vox[2], vrt_pkg::FACE_NORTH, vrt_pkg::ST_BEYOND, '0, count);
      return;
    end
    lim = (step_cap == 0) ? 10'd1 : step_cap;
    if (count >= lim) begin
      active = 0;
      ends++;
      push(vox[0], vox[1], vox[2], vrt_pkg::FACE_NORTH, vrt_pkg::ST_STEP_LIMIT, '0, count);
      return;
    end
    nv = vox[ax] + (pos[ax] ? 1 : -1);
    if (nv < -32768 || nv > 32767) begin
      active = 0;
      ends++;
      push(vox[0], vox[1], vox[2], vrt_pkg::FACE_NORTH, vrt_pkg::ST_COORD_OVF, '0, count);
      return;
    end
    vox[ax] = 17'(nv);
    bnd[ax] = sat(longint'(bnd[ax]) + longint'(dlt[ax]));
    case (ax)
      0: face = pos[0] ? vrt_pkg::FACE_WEST : vrt_pkg::FACE_EAST;
      1: face = pos[1] ? vrt_pkg::FACE_DOWN : vrt_pkg::FACE_UP;
      default: face = pos[2] ? vrt_pkg::FACE_NORTH : vrt_pkg::FACE_SOUTH;
    endcase
    push(vox[0], vox[1], vox[2], face, vrt_pkg::ST_TEST, '0, count);
  endfunction

  function void check_result(vrt_pkg::vrt_out_t got);
    vrt_pkg::vrt_out_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, actual %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.voxel_x !== exp_r.voxel_x || got.voxel_y !== exp_r.voxel_y ||
        got.voxel_z !== exp_r.voxel_z || got.face !== exp_r.face ||
        got.status !== exp_r.status || got.hit_distance !== exp_r.hit_distance ||
        got.tested_cnt !== exp_r.tested_cnt) begin
      $display("%0t: result differs, expected %p, actual %p", $time, exp_r, got);
      errors++;
    end
  endfunction
endclass

module tb_voxel_ray_traversal;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  vrt_pkg::vrt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  vrt_pkg::vrt_out_t out_data;
  logic cfg_we = 0;
  logic [9:0] cfg_wdata = '0;

  vrt_scoreboard sb;
  bit idle_on = 1;
  bit hold_long = 0;
  int quiet = 0;
  int sent = 0;

  localparam int WATCHDOG = 20000;

  voxel_ray_traversal uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // sample handshakes on the edge, after the previous drive settled
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet > WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("voxel_ray_traversal: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, or a long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        for (int i = 0; i < 400; i++) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // valid stays up after a request until the next one or a gap replaces it
  task automatic send(vrt_pkg::vrt_in_t q);
    int n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
    in_data <= q;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_cap(logic [9:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sb.step_cap = v;
  endtask

  function automatic vrt_pkg::vrt_in_t ray(int ox, int oy, int oz, int dx, int dy,
                                           int dz, int rl);
    vrt_pkg::vrt_in_t q;
    q = '0;
    q.func = 1'b0;
    q.origin_x = 24'(ox); q.origin_y = 24'(oy); q.origin_z = 24'(oz);
    q.dir_x = 16'(dx); q.dir_y = 16'(dy); q.dir_z = 16'(dz);
    q.range_limit = 24'(rl);
    q.voxel_solid = 1'($urandom_range(0, 1));
    return q;
  endfunction

  function automatic vrt_pkg::vrt_in_t verdict(bit solid);
    vrt_pkg::vrt_in_t q;
    q = '0;
    q.func = 1'b1;
    q.voxel_solid = solid;
    // other fields are don't-care on a verdict: fill with noise
    q.origin_x = 24'($urandom); q.origin_y = 24'($urandom); q.origin_z = 24'($urandom);
    q.dir_x = 16'($urandom); q.dir_y = 16'($urandom); q.dir_z = 16'($urandom);
    q.range_limit = 24'($urandom);
    return q;
  endfunction

  function automatic int rnd_dir();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32767;
      2: return -32768;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  task automatic random_ray(int max_verdicts);
    int ox, oy, oz, dx, dy, dz, rl, nv;
    if ($urandom_range(0, 9) == 0) begin
      ox = $urandom; oy = $urandom; oz = $urandom;
    end else if ($urandom_range(0, 7) == 0) begin
      // near the coordinate edge so steps can overflow
      ox = $urandom_range(0, 1) ? 32'h7FFF00 + $urandom_range(0, 255)
                                : -32'h800000 + $urandom_range(0, 255);
      oy = $urandom_range(0, 4095) - 2048;
      oz = $urandom_range(0, 4095) - 2048;
    end else begin
      ox = $urandom_range(0, 8191) - 4096;
      oy = $urandom_range(0, 8191) - 4096;
      oz = $urandom_range(0, 8191) - 4096;
    end
    dx = rnd_dir(); dy = rnd_dir(); dz = rnd_dir();
    if ($urandom_range(0, 29) == 0) begin dx = 0; dy = 0; dz = 0; end
    rl = $urandom_range(0, 3) == 0 ? $urandom_range(0, 24'hFFFFFF)
                                   : $urandom_range(0, 8000);
    send(ray(ox, oy, oz, dx, dy, dz, rl));
    nv = $urandom_range(1, max_verdicts);
    for (int i = 0; i < nv; i++) send(verdict($urandom_range(0, 15) == 0));
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes and each ending
    send(verdict(1));                                     // no active ray
    send(ray(0, 0, 0, 0, 0, 0, 100));                     // zero direction
    send(ray(24'h7FFFFF, -24'h800000, 0, 32767, 0, 0, 5)); // at edge, ok
    send(verdict(0));                                     // +x overflows
    send(ray(128, 128, 128, 32767, 32767, 32767, 24'hFFFFFF)); // tie goes z
    send(verdict(0));
    send(verdict(0));
    send(verdict(1));
    send(ray(-1, 200, 10, -32768, -20000, 5000, 0));       // beyond at once
    send(verdict(0));
    send(ray(0, 0, 0, 0, 1, 0, 24'hFFFFFF));               // huge delta
    send(verdict(0));
    send(verdict(1));
    send(ray(-24'h800000, 24'h7FFFFF, -24'h800000, 0, 0, -32768, 24'hFFFFFF));
    send(verdict(0));
    send(verdict(0));
    send(verdict(1));
    write_cap(1);
    send(ray(300, 300, 300, 1000, -1000, 30000, 24'hFFFFFF));
    send(verdict(0));                                     // step limit
    write_cap(0);
    send(ray(300, 300, 300, 1000, -1000, 30000, 24'hFFFFFF));
    send(verdict(0));
    write_cap(10'h3FF);

    // random phases with different step limits
    for (int ph = 0; ph < 6; ph++) begin
      write_cap(ph == 0 ? 10'h3FF : ph == 1 ? 10'd1 : 10'($urandom_range(2, 40)));
      for (int r = 0; r < 20; r++) random_ray(ph == 0 ? 24 : 12);
      if (ph == 2) begin
        hold_long = 1;
        for (int r = 0; r < 6; r++) random_ray(10);
        drain();                                          // sender pauses
      end
    end
    write_cap(vrt_pkg::STEP_LIM_RST);
    idle_on = 0;
    while (sent < 1350) random_ray(10);

    drain();
    $display("sent %0d requests: %0d hits, %0d other ray endings", sent, sb.hits, sb.ends);
    $display("step limits varied from 0 to 1023, with stalls on both sides");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("voxel_ray_traversal: match");
    else
      $display("voxel_ray_traversal: mismatch");
    $finish;
  end
endmodule
